### hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, types and helpers for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int TOP_ORDER  = 10;
    localparam int POOL_UNITS = 1 << TOP_ORDER;
    localparam int ADDR_W     = TOP_ORDER;
    localparam int SIZE_W     = TOP_ORDER + 1;
    localparam int ORD_W      = 4;
    localparam int NODE_W     = TOP_ORDER + 1;
    localparam int ROW_BITS   = 32;
    localparam int BIT_W      = 5;
    localparam int ROWS       = (2 * POOL_UNITS) / ROW_BITS;
    localparam int ROW_W      = NODE_W - BIT_W;
    localparam int REQ_W      = 12;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // owner table entry
    typedef struct packed {
        logic                 valid;
        logic [ORD_W-1:0]     order;
        logic [SIZE_W-1:0]    request;
    } owner_t;

    // heap index of the node of order k starting at address a
    function automatic logic [NODE_W-1:0] node_of(input logic [ORD_W-1:0] k,
                                                  input logic [ADDR_W-1:0] a);
        logic [NODE_W-1:0] base;
        logic [ADDR_W-1:0] off;
        begin
            base = NODE_W'(1) << (ORD_W'(TOP_ORDER) - k);
            off  = a >> k;
            return base + NODE_W'(off);
        end
    endfunction

endpackage

### hw/rtl/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a 1024-unit pool with allocate and free commands.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over its owner table and tree
// map and takes no word meanwhile. It then works on one word at a time. The
// tree of free bits sits in a single-port memory of 32-bit rows, and every
// row touched is first read, then checked and written. An allocate picks the
// lowest order at or above its request that holds a free block, scans the
// rows at that order (up to 32 rows at order zero) and sets one buddy bit
// per split; a free clears the owner entry, merges each free buddy in turn
// and sets the bit of the merged block; a refused word goes straight to its
// result. Each word ends with a return to idle before the next is taken.
// A finished result waits in the output register while the next word is
// taken in.
module buddy_block_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        operation,
    input  logic [11:0]                 req_units,
    input  logic [bba_pkg::ADDR_W-1:0]  block_address,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic [bba_pkg::ADDR_W-1:0]  granted_address,
    output logic [bba_pkg::SIZE_W-1:0]  granted_size,
    output logic [bba_pkg::SIZE_W-1:0]  free_total,
    output logic [bba_pkg::ADDR_W-1:0]  internal_waste,
    output logic [bba_pkg::SIZE_W-1:0]  external_waste
);
    import bba_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_FIND  = 11'b00000000100,
        S_SCRD  = 11'b00000001000,
        S_SCCHK = 11'b00000010000,
        S_SETRD = 11'b00000100000,
        S_SETWR = 11'b00001000000,
        S_FRCHK = 11'b00010000000,
        S_MGRD  = 11'b00100000000,
        S_MGCHK = 11'b01000000000,
        S_FIN   = 11'b10000000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      clr_reg, clr_next;
    logic                   op_reg, op_next;
    logic [REQ_W-1:0]       req_reg, req_next;
    logic [ORD_W-1:0]       k_reg, k_next;
    logic [ORD_W-1:0]       j_reg, j_next;
    logic [ADDR_W-1:0]      a_reg, a_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic [1:0]             st_reg, st_next;
    logic [ADDR_W-1:0]      ga_reg, ga_next;
    logic [SIZE_W-1:0]      gs_reg, gs_next;
    logic [SIZE_W-1:0]      used_reg, used_next;
    logic [SIZE_W-1:0]      waste_reg, waste_next;
    logic [SIZE_W-1:0]      cnt_reg [TOP_ORDER+1];
    logic [SIZE_W-1:0]      cnt_next [TOP_ORDER+1];

    logic                   ov_reg;
    logic [1:0]             ost_reg;
    logic [ADDR_W-1:0]      oga_reg;
    logic [SIZE_W-1:0]      ogs_reg, ofree_reg, oext_reg;
    logic [ADDR_W-1:0]      owaste_reg;

    // tree map memory and owner table
    logic [ROW_BITS-1:0]    fmap [ROWS];
    logic [ROW_BITS-1:0]    fm_rd_reg;
    logic [ROW_W-1:0]       fm_addr;
    logic                   fm_we;
    logic [ROW_BITS-1:0]    fm_wdata;
    owner_t                 own [POOL_UNITS];
    owner_t                 own_rd_reg;
    logic [ADDR_W-1:0]      own_addr;
    logic                   own_we;
    owner_t                 own_wdata;

    logic                   accept;
    logic                   load_out;

    // scan helpers
    logic [NODE_W-1:0]      lo_node;
    logic [NODE_W:0]        hi_node;
    logic [ROW_BITS-1:0]    row_mask;
    logic                   hit;
    logic [BIT_W-1:0]       hit_bit;
    logic [NODE_W-1:0]      hit_node;
    logic [ADDR_W-1:0]      hit_addr;
    logic [NODE_W-1:0]      set_node;
    logic [NODE_W-1:0]      mg_node;
    logic [ADDR_W-1:0]      set_addr;

    // request order and first order with a free block
    logic [ORD_W-1:0]       req_ord;
    logic [ORD_W-1:0]       fit_ord;
    logic                   fit_ok;
    logic [NODE_W-1:0]      fit_node;
    logic [ORD_W-1:0]       big_ord;
    logic                   big_ok;
    logic [ORD_W-1:0]       fr_ord;
    logic [SIZE_W-1:0]      fr_size;
    logic [SIZE_W-1:0]      free_units;
    logic [SIZE_W-1:0]      big_size;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign load_out = (state_reg == S_FIN) && (!ov_reg || !out_stall);

    // row scan at order j
    always_comb
    begin
        lo_node = node_of(j_reg, '0);
        hi_node = {lo_node, 1'b0};
        hit     = 1'b0;
        hit_bit = '0;
        for (int b = 0; b < ROW_BITS; b++)
        begin
            row_mask[b] = ({row_reg, BIT_W'(b)} >= lo_node)
                       && ({1'b0, row_reg, BIT_W'(b)} < hi_node);
        end
        for (int b = ROW_BITS - 1; b >= 0; b--)
        begin
            if (row_mask[b] && fm_rd_reg[b])
            begin
                hit     = 1'b1;
                hit_bit = BIT_W'(b);
            end
        end
        hit_node = {row_reg, hit_bit};
        hit_addr = ADDR_W'(hit_node - lo_node) << j_reg;
    end

    // node addresses for set and merge steps
    always_comb
    begin
        set_addr = (op_reg == OP_ALLOC) ? (a_reg | (ADDR_W'(1) << j_reg)) : a_reg;
        set_node = node_of(j_reg, set_addr);
        mg_node  = node_of(j_reg, a_reg ^ (ADDR_W'(1) << j_reg));
    end

    // order arithmetic over the eleven orders
    always_comb
    begin
        req_ord = '0;
        for (int i = 0; i <= TOP_ORDER; i++)
        begin
            if ((REQ_W'(1) << i) < req_reg)
            begin
                req_ord = req_ord + ORD_W'(1);
            end
        end
        fit_ok  = 1'b0;
        fit_ord = '0;
        big_ok  = 1'b0;
        big_ord = '0;
        for (int i = TOP_ORDER; i >= 0; i--)
        begin
            if ((ORD_W'(i) >= req_ord) && (cnt_reg[i] != '0))
            begin
                fit_ok  = 1'b1;
                fit_ord = ORD_W'(i);
            end
        end
        for (int i = 0; i <= TOP_ORDER; i++)
        begin
            if (cnt_reg[i] != '0)
            begin
                big_ok  = 1'b1;
                big_ord = ORD_W'(i);
            end
        end
        fit_node   = node_of(fit_ord, '0);
        fr_ord     = (own_rd_reg.order > ORD_W'(TOP_ORDER)) ? ORD_W'(TOP_ORDER)
                                                           : own_rd_reg.order;
        fr_size    = SIZE_W'(1) << fr_ord;
        free_units = SIZE_W'(POOL_UNITS) - used_reg;
        big_size   = big_ok ? (SIZE_W'(1) << big_ord) : '0;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        op_next    = op_reg;
        req_next   = req_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        a_next     = a_reg;
        row_next   = row_reg;
        st_next    = st_reg;
        ga_next    = ga_reg;
        gs_next    = gs_reg;
        used_next  = used_reg;
        waste_next = waste_reg;
        for (int i = 0; i <= TOP_ORDER; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        fm_addr   = row_reg;
        fm_we     = 1'b0;
        fm_wdata  = fm_rd_reg;
        own_addr  = a_reg;
        own_we    = 1'b0;
        own_wdata = own_rd_reg;

        case (state_reg)
            S_CLEAR:
            begin
                own_addr  = clr_reg;
                own_we    = 1'b1;
                own_wdata = '0;
                fm_addr   = clr_reg[ROW_W-1:0];
                fm_we     = (clr_reg < ADDR_W'(ROWS));
                fm_wdata  = (clr_reg == '0) ? ROW_BITS'(2) : '0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(POOL_UNITS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                own_addr = block_address;
                if (accept)
                begin
                    op_next  = operation;
                    req_next = req_units;
                    a_next   = block_address;
                    st_next  = ST_DONE;
                    ga_next  = '0;
                    gs_next  = '0;
                    state_next = (operation == OP_ALLOC) ? S_FIND : S_FRCHK;
                end
            end
            S_FIND:
            begin
                k_next = req_ord;
                j_next = fit_ord;
                row_next = fit_node[NODE_W-1:BIT_W];
                if ((req_reg > REQ_W'(POOL_UNITS)) || !fit_ok)
                begin
                    st_next    = ST_NOFIT;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_SCRD;
                end
            end
            S_SCRD:
            begin
                state_next = S_SCCHK;
            end
            S_SCCHK:
            begin
                if (hit)
                begin
                    fm_we    = 1'b1;
                    fm_wdata = fm_rd_reg & ~(ROW_BITS'(1) << hit_bit);
                    cnt_next[j_reg] = cnt_reg[j_reg] - SIZE_W'(1);
                    own_addr  = hit_addr;
                    own_we    = 1'b1;
                    own_wdata = '{valid: 1'b1, order: k_reg,
                                  request: SIZE_W'(req_reg)};
                    a_next     = hit_addr;
                    ga_next    = hit_addr;
                    gs_next    = SIZE_W'(1) << k_reg;
                    used_next  = used_reg + (SIZE_W'(1) << k_reg);
                    waste_next = waste_reg + (SIZE_W'(1) << k_reg) - SIZE_W'(req_reg);
                    if (j_reg > k_reg)
                    begin
                        j_next     = j_reg - ORD_W'(1);
                        state_next = S_SETRD;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    row_next   = row_reg + ROW_W'(1);
                    state_next = S_SCRD;
                end
            end
            S_SETRD:
            begin
                fm_addr    = set_node[NODE_W-1:BIT_W];
                state_next = S_SETWR;
            end
            S_SETWR:
            begin
                fm_addr  = set_node[NODE_W-1:BIT_W];
                fm_we    = 1'b1;
                fm_wdata = fm_rd_reg | (ROW_BITS'(1) << set_node[BIT_W-1:0]);
                cnt_next[j_reg] = cnt_reg[j_reg] + SIZE_W'(1);
                if ((op_reg == OP_ALLOC) && (j_reg > k_reg))
                begin
                    j_next     = j_reg - ORD_W'(1);
                    state_next = S_SETRD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FRCHK:
            begin
                if (!own_rd_reg.valid)
                begin
                    st_next    = ST_IGNORED;
                    state_next = S_FIN;
                end
                else
                begin
                    own_we          = 1'b1;
                    own_wdata.valid = 1'b0;
                    used_next  = used_reg - fr_size;
                    waste_next = waste_reg - (fr_size - own_rd_reg.request);
                    gs_next    = fr_size;
                    j_next     = fr_ord;
                    state_next = (fr_ord == ORD_W'(TOP_ORDER)) ? S_SETRD : S_MGRD;
                end
            end
            S_MGRD:
            begin
                fm_addr    = mg_node[NODE_W-1:BIT_W];
                state_next = S_MGCHK;
            end
            S_MGCHK:
            begin
                fm_addr = mg_node[NODE_W-1:BIT_W];
                if (fm_rd_reg[mg_node[BIT_W-1:0]])
                begin
                    fm_we    = 1'b1;
                    fm_wdata = fm_rd_reg & ~(ROW_BITS'(1) << mg_node[BIT_W-1:0]);
                    cnt_next[j_reg] = cnt_reg[j_reg] - SIZE_W'(1);
                    a_next = a_reg & ~(ADDR_W'(1) << j_reg);
                    j_next = j_reg + ORD_W'(1);
                    state_next = (j_reg == ORD_W'(TOP_ORDER - 1)) ? S_SETRD : S_MGRD;
                end
                else
                begin
                    state_next = S_SETRD;
                end
            end
            S_FIN:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            used_reg  <= '0;
            waste_reg <= '0;
            ov_reg    <= 1'b0;
            for (int i = 0; i <= TOP_ORDER; i++)
            begin
                cnt_reg[i] <= (i == TOP_ORDER) ? SIZE_W'(1) : '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            used_reg  <= used_next;
            waste_reg <= waste_next;
            for (int i = 0; i <= TOP_ORDER; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
            if (load_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // working and output word registers
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        req_reg <= req_next;
        k_reg   <= k_next;
        j_reg   <= j_next;
        a_reg   <= a_next;
        row_reg <= row_next;
        st_reg  <= st_next;
        ga_reg  <= ga_next;
        gs_reg  <= gs_next;
        if (load_out)
        begin
            ost_reg    <= st_reg;
            oga_reg    <= ga_reg;
            ogs_reg    <= gs_reg;
            ofree_reg  <= free_units;
            owaste_reg <= (waste_reg > SIZE_W'(POOL_UNITS - 1)) ? ADDR_W'(POOL_UNITS - 1)
                                                               : waste_reg[ADDR_W-1:0];
            oext_reg   <= free_units - big_size;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (fm_we)
        begin
            fmap[fm_addr] <= fm_wdata;
        end
        fm_rd_reg <= fmap[fm_addr];
    end

    always_ff @(posedge clk)
    begin
        if (own_we)
        begin
            own[own_addr] <= own_wdata;
        end
        own_rd_reg <= own[own_addr];
    end

    assign out_valid       = ov_reg;
    assign status          = ost_reg;
    assign granted_address = oga_reg;
    assign granted_size    = ogs_reg;
    assign free_total      = ofree_reg;
    assign internal_waste  = owaste_reg;
    assign external_waste  = oext_reg;

`ifndef ASSERT_OFF
    // allocated units never exceed the pool
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= SIZE_W'(POOL_UNITS))
        else $error("used units exceed pool");

    // a failed or ignored word grants nothing
    a_fail_size: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && (ost_reg != ST_DONE)) |-> (ogs_reg == '0 && oga_reg == '0))
        else $error("failed word carries a grant");

    // an accepted word keeps the input stalled in the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input not stalled after accept");

    // a scan never runs past the last row of the pool tree
    a_scan_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCCHK && !hit) |-> (row_reg != ROW_W'(ROWS - 1)))
        else $error("scan ran off the tree");
`endif

endmodule

### test/tb_buddy_block_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator
// Self-checking bench for the buddy allocator: a directed table of allocate
// and free words, then random sequences that fill and drain the pool, with
// every result compared against a local model of the buddy tree.
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator;
    import bba_pkg::*;

    typedef struct packed {
        logic [1:0]        st;
        logic [ADDR_W-1:0] gaddr;
        logic [SIZE_W-1:0] gsize;
        logic [SIZE_W-1:0] freeu;
        logic [ADDR_W-1:0] iwaste;
        logic [SIZE_W-1:0] ewaste;
    } alloc_result_t;

    typedef struct packed {
        logic              op;
        logic [11:0]       req;
        logic [ADDR_W-1:0] addr;
        logic              fixed;
        alloc_result_t     res;
    } stim_row_t;

    localparam int LIMIT_CYCLES = 600000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic operation = OP_ALLOC;
    logic [11:0] req_units = '0;
    logic [ADDR_W-1:0] block_address = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] status;
    logic [ADDR_W-1:0] granted_address;
    logic [SIZE_W-1:0] granted_size;
    logic [SIZE_W-1:0] free_total;
    logic [ADDR_W-1:0] internal_waste;
    logic [SIZE_W-1:0] external_waste;

    // model of the buddy tree
    bit              tree_free [2*POOL_UNITS];
    bit              blk_live  [POOL_UNITS];
    int unsigned     blk_order [POOL_UNITS];
    int unsigned     blk_req   [POOL_UNITS];
    int unsigned     used_units;
    int unsigned     waste_units;

    alloc_result_t   pending_results [$];
    alloc_result_t   typed_results   [$];
    bit              typed_flags     [$];
    int unsigned     live_addrs      [$];

    int mismatches = 0;
    int results_seen = 0;
    int allocs_sent = 0;
    int frees_sent = 0;
    int nofit_seen = 0;
    int ignored_seen = 0;
    int cycles = 0;
    bit quiet_mode = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    buddy_block_allocator uut (.*);

    always #5 clk = ~clk;

    // timeout watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int unsigned heap_node(int unsigned k, int unsigned a);
        return ((1 << (TOP_ORDER - k)) + (a >> k)) & (2*POOL_UNITS - 1);
    endfunction

    function automatic int lowest_free_at(int unsigned k);
        int unsigned n;
        n = 1 << (TOP_ORDER - k);
        for (int unsigned i = 0; i < n; i++)
            if (tree_free[n + i])
                return int'(i << k);
        return -1;
    endfunction

    function automatic void reset_tree();
        foreach (tree_free[i]) tree_free[i] = 1'b0;
        foreach (blk_live[i])
        begin
            blk_live[i] = 1'b0;
            blk_order[i] = 0;
            blk_req[i] = 0;
        end
        tree_free[heap_node(TOP_ORDER, 0)] = 1'b1;
        used_units = 0;
        waste_units = 0;
    endfunction

    // apply one word to the model and return the result it should give
    function automatic alloc_result_t predict_buddy(logic op, logic [11:0] req,
                                                    logic [ADDR_W-1:0] addr);
        alloc_result_t r;
        int unsigned k, j, a, b, big, fu;
        int found;
        r = '0;
        if (op == OP_ALLOC)
        begin
            k = 0;
            found = -1;
            while (k < 13 && (1 << k) < req) k++;
            if (k > TOP_ORDER)
                r.st = ST_NOFIT;
            else
            begin
                for (j = k; j <= TOP_ORDER; j++)
                begin
                    found = lowest_free_at(j);
                    if (found >= 0) break;
                end
                if (found < 0)
                    r.st = ST_NOFIT;
                else
                begin
                    a = found;
                    tree_free[heap_node(j, a)] = 1'b0;
                    while (j > k)
                    begin
                        j--;
                        tree_free[heap_node(j, a + (1 << j))] = 1'b1;
                    end
                    blk_live[a] = 1'b1;
                    blk_order[a] = k;
                    blk_req[a] = int'(req);
                    used_units += 1 << k;
                    waste_units += (1 << k) - int'(req);
                    r.st = ST_DONE;
                    r.gaddr = ADDR_W'(a);
                    r.gsize = SIZE_W'(1 << k);
                end
            end
        end
        else if (!blk_live[addr])
            r.st = ST_IGNORED;
        else
        begin
            a = addr;
            k = blk_order[a];
            blk_live[a] = 1'b0;
            used_units -= 1 << k;
            waste_units -= (1 << k) - blk_req[a];
            r.st = ST_DONE;
            r.gsize = SIZE_W'(1 << k);
            while (k < TOP_ORDER)
            begin
                b = a ^ (1 << k);
                if (!tree_free[heap_node(k, b)]) break;
                tree_free[heap_node(k, b)] = 1'b0;
                if (b < a) a = b;
                k++;
            end
            tree_free[heap_node(k, a)] = 1'b1;
        end
        fu = POOL_UNITS - used_units;
        big = 0;
        for (int kk = TOP_ORDER; kk >= 0; kk--)
            if (lowest_free_at(kk) >= 0)
            begin
                big = 1 << kk;
                break;
            end
        r.freeu = SIZE_W'(fu);
        r.iwaste = (waste_units > 1023) ? 10'd1023 : ADDR_W'(waste_units);
        r.ewaste = SIZE_W'(fu - big);
        return r;
    endfunction

    // hand one word to the block and queue its expected result
    task automatic send_word(logic op, logic [11:0] req, logic [ADDR_W-1:0] addr,
                             logic fixed, alloc_result_t typed);
        alloc_result_t r;
        r = predict_buddy(op, req, addr);
        pending_results = {pending_results, r};
        typed_results = {typed_results, typed};
        typed_flags = {typed_flags, fixed};
        if (op == OP_ALLOC)
        begin
            allocs_sent++;
            if (r.st == ST_DONE) live_addrs = {live_addrs, 32'(r.gaddr)};
        end
        else
        begin
            frees_sent++;
            foreach (live_addrs[i])
                if (live_addrs[i] == addr && r.st == ST_DONE)
                begin
                    live_addrs.delete(i);
                    break;
                end
        end
        // sender gap
        while (!quiet_mode && $urandom_range(99) < 29)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        req_units <= req;
        block_address <= addr;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic logic [11:0] random_size();
        case ($urandom_range(9))
            0: return 12'($urandom_range(4095));
            1: return 12'($urandom_range(1));
            2, 3: return 12'($urandom_range(64));
            4: return 12'($urandom_range(256));
            default: return 12'($urandom_range(16));
        endcase
    endfunction

    // receiver stall pattern and long hold-off
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            out_stall <= 1'b1;
            repeat (400) @(posedge clk);
            hold_done <= 1'b1;
            out_stall <= 1'b0;
        end
        else
            out_stall <= (!quiet_mode && $urandom_range(99) < 29);
    end

    // result checker
    always @(posedge clk)
    begin
        alloc_result_t got, want;
        if (out_valid && !out_stall && rst_n)
        begin
            got = '{status, granted_address, granted_size, free_total,
                    internal_waste, external_waste};
            results_seen++;
            if (got.st == ST_NOFIT) nofit_seen++;
            if (got.st == ST_IGNORED) ignored_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (typed_flags[0] && typed_results[0] != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("table row disagrees: table %p model %p",
                                 typed_results[0], want);
                end
                typed_flags.delete(0);
                typed_results.delete(0);
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected %p got %p",
                                 results_seen, want, got);
                end
            end
        end
    end

    stim_row_t table_rows [$];

    initial
    begin
        int drain;
        logic [ADDR_W-1:0] a;
        reset_tree();
        // directed rows: op, size, address, typed, status/addr/size/free/iw/ew
        table_rows = '{
            '{OP_FREE,  12'd0,    10'd0,   1'b1, '{ST_IGNORED, 0, 0, 1024, 0, 0}},
            '{OP_ALLOC, 12'd1025, 10'd0,   1'b1, '{ST_NOFIT, 0, 0, 1024, 0, 0}},
            '{OP_ALLOC, 12'd4095, 10'd0,   1'b1, '{ST_NOFIT, 0, 0, 1024, 0, 0}},
            '{OP_ALLOC, 12'd1024, 10'd0,   1'b1, '{ST_DONE, 0, 1024, 0, 0, 0}},
            '{OP_ALLOC, 12'd1,    10'd0,   1'b1, '{ST_NOFIT, 0, 0, 0, 0, 0}},
            '{OP_FREE,  12'd0,    10'd1023, 1'b1, '{ST_IGNORED, 0, 0, 0, 0, 0}},
            '{OP_FREE,  12'd4095, 10'd0,   1'b1, '{ST_DONE, 0, 1024, 1024, 0, 0}},
            '{OP_ALLOC, 12'd0,    10'd1023, 1'b1, '{ST_DONE, 0, 1, 1023, 1, 511}},
            '{OP_ALLOC, 12'd3,    10'd0,   1'b0, '0},
            '{OP_ALLOC, 12'd1000, 10'd0,   1'b0, '0},
            '{OP_ALLOC, 12'd513,  10'd0,   1'b0, '0},
            '{OP_ALLOC, 12'd1,    10'd0,   1'b0, '0},
            '{OP_FREE,  12'd0,    10'd4,   1'b0, '0},
            '{OP_FREE,  12'd0,    10'd2,   1'b0, '0},
            '{OP_FREE,  12'd0,    10'd0,   1'b0, '0},
            '{OP_FREE,  12'd0,    10'd1,   1'b0, '0},
            '{OP_FREE,  12'd0,    10'd512, 1'b0, '0},
            '{OP_ALLOC, 12'd512,  10'd0,   1'b0, '0},
            '{OP_ALLOC, 12'd256,  10'd0,   1'b0, '0},
            '{OP_FREE,  12'd0,    10'd0,   1'b0, '0},
            '{OP_FREE,  12'd0,    10'd512, 1'b0, '0}
        };
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        foreach (table_rows[i])
            send_word(table_rows[i].op, table_rows[i].req, table_rows[i].addr,
                      table_rows[i].fixed, table_rows[i].res);

        // random part: fill and drain with mostly valid frees
        for (int n = 0; n < 1300; n++)
        begin
            quiet_mode = (n >= 300 && n < 450);
            if (n == 600) hold_req = 1'b1;
            if (n >= 1000 && n < 1100)
                send_word(OP_ALLOC, 12'd0, ADDR_W'($urandom), 1'b0, '0);
            else if ($urandom_range(99) < 50 || live_addrs.size() == 0)
                send_word(OP_ALLOC, random_size(), ADDR_W'($urandom), 1'b0, '0);
            else if ($urandom_range(99) < 85)
            begin
                a = ADDR_W'(live_addrs[$urandom_range(live_addrs.size() - 1)]);
                send_word(OP_FREE, 12'($urandom), a, 1'b0, '0);
            end
            else
                send_word(OP_FREE, 12'($urandom), ADDR_W'($urandom), 1'b0, '0);
        end
        in_valid <= 1'b0;

        drain = 0;
        while (pending_results.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (200) @(posedge clk);
        $display("covered %0d allocates and %0d frees, %0d results checked",
                 allocs_sent, frees_sent, results_seen);
        $display("no-fit results %0d, ignored frees %0d, mismatches %0d",
                 nofit_seen, ignored_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
